[rtl/rfld_pkg.sv]
`timescale 1ns / 1ps

package rfld_pkg;

    localparam int HDR_W   = 40;
    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 40;
    localparam int IDX_W   = 2;
    localparam int HDR_LEN = 5;

    localparam logic [IDX_W-1:0] REG_HEADER_PATTERN = 2'd0;
    localparam logic [IDX_W-1:0] REG_FOOTER_FIRST   = 2'd1;
    localparam logic [IDX_W-1:0] REG_FOOTER_SECOND  = 2'd2;

    localparam logic [HDR_W-1:0]  RST_HEADER_PATTERN = '0;
    localparam logic [BYTE_W-1:0] RST_FOOTER_FIRST   = 8'hAC;
    localparam logic [BYTE_W-1:0] RST_FOOTER_SECOND  = 8'hCA;

    localparam logic [1:0] PHASE_SEARCH = 2'd0;
    localparam logic [1:0] PHASE_DECODE = 2'd1;
    localparam logic [1:0] PHASE_CLOSED = 2'd2;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              is_status;
        logic              header_seen;
        logic              footer_seen;
        logic              sum_ok;
    } t_result;

endpackage

[rtl/rfld_if.sv]
`timescale 1ns / 1ps

interface rfld_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_buffer;

    modport source (output valid, output rx_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

interface rfld_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_status;
    logic       header_seen;
    logic       footer_seen;
    logic       sum_ok;

    modport source (output valid, output data_byte, output is_status, output header_seen,
                    output footer_seen, output sum_ok, input ready);
    modport sink   (input valid, input data_byte, input is_status, input header_seen,
                    input footer_seen, input sum_ok, output ready);
endinterface

[rtl/rf_frame_line_decoder.sv]
`timescale 1ns / 1ps

// Frame decoder for a line-coded radio receive buffer. Raw bytes enter one per beat; until the
// configured five-byte header is matched they only fill a compare window, after that each byte
// gives line bits 7, 5, 3 and 1, every fifth line bit is dropped and the nibbles pair into
// payload bytes that leave as soon as they complete. A byte equal to either footer value closes
// the frame with a status beat; end_of_buffer always produces one if none was sent yet, with
// footer_seen low meaning the frame must be thrown away. The decode of a byte is a single
// registered step, so one input beat is taken every cycle while input ready is high. Results
// go through a four-entry output queue and leave at one per cycle while the sink is ready;
// input ready is held low while fewer than two queue places are free, so a last byte that
// completes a data byte and also needs the closing status beat can push both results at once.
// Configuration must be written by the user only while the block is idle; it is not enforced.

module rf_frame_line_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rfld_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [rfld_pkg::CFG_W-1:0]    i_cfg_data,
    rfld_in_if.sink                       i_rx,
    rfld_out_if.source                    o_res
);

    logic [rfld_pkg::HDR_W-1:0]  r_header_pattern;
    logic [rfld_pkg::BYTE_W-1:0] r_footer_first;
    logic [rfld_pkg::BYTE_W-1:0] r_footer_second;

    logic [rfld_pkg::HDR_W-1:0]  r_window, n_window;
    logic [2:0]                  r_fill, n_fill;
    logic [1:0]                  r_phase, n_phase;
    logic [3:0]                  r_group_bits, n_group_bits;
    logic [2:0]                  r_group_count, n_group_count;
    logic [3:0]                  r_high, n_high;
    logic                        r_held, n_held;
    logic [rfld_pkg::BYTE_W-1:0] r_sum, n_sum;

    rfld_pkg::t_result           r_mem [rfld_pkg::Q_DEPTH];
    logic [rfld_pkg::Q_AW-1:0]   r_head, r_tail;
    logic [rfld_pkg::Q_CW-1:0]   r_count;

    rfld_pkg::t_result           w_item0, w_item1;
    logic [1:0]                  w_push;
    logic                        w_in_acc, w_out_acc;
    logic [rfld_pkg::BYTE_W-1:0] w_byte;
    logic                        w_got;
    logic                        w_bit;
    logic [rfld_pkg::Q_AW-1:0]   w_tail1;

    assign w_in_acc  = i_rx.valid & i_rx.ready;
    assign w_out_acc = o_res.valid & o_res.ready;
    assign i_rx.ready = (r_count <= rfld_pkg::Q_CW'(rfld_pkg::Q_DEPTH - 2));
    assign w_tail1 = r_tail + rfld_pkg::Q_AW'(1);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_pattern <= rfld_pkg::RST_HEADER_PATTERN;
            r_footer_first   <= rfld_pkg::RST_FOOTER_FIRST;
            r_footer_second  <= rfld_pkg::RST_FOOTER_SECOND;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rfld_pkg::REG_HEADER_PATTERN: r_header_pattern <= i_cfg_data;
                rfld_pkg::REG_FOOTER_FIRST:   r_footer_first   <= i_cfg_data[7:0];
                rfld_pkg::REG_FOOTER_SECOND:  r_footer_second  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // decode of one byte
    always_comb begin
        n_window      = r_window;
        n_fill        = r_fill;
        n_phase       = r_phase;
        n_group_bits  = r_group_bits;
        n_group_count = r_group_count;
        n_high        = r_high;
        n_held        = r_held;
        n_sum         = r_sum;
        w_item0       = '0;
        w_item1       = '0;
        w_push        = 2'd0;
        w_byte        = '0;
        w_got         = 1'b0;
        w_bit         = 1'b0;
        if (w_in_acc) begin
            case (r_phase)
                rfld_pkg::PHASE_SEARCH: begin
                    n_window = {r_window[rfld_pkg::HDR_W-9:0], i_rx.rx_byte};
                    if (r_fill < 3'(rfld_pkg::HDR_LEN)) begin
                        n_fill = r_fill + 3'd1;
                    end
                    if (n_fill == 3'(rfld_pkg::HDR_LEN) && n_window == r_header_pattern) begin
                        n_phase = rfld_pkg::PHASE_DECODE;
                    end
                end
                rfld_pkg::PHASE_DECODE: begin
                    if (i_rx.rx_byte == r_footer_first || i_rx.rx_byte == r_footer_second) begin
                        w_item0.is_status   = 1'b1;
                        w_item0.header_seen = 1'b1;
                        w_item0.footer_seen = 1'b1;
                        w_item0.sum_ok      = (r_sum == '0);
                        w_push  = 2'd1;
                        n_phase = rfld_pkg::PHASE_CLOSED;
                    end else begin
                        for (int k = 0; k < 4; k++) begin
                            w_bit = i_rx.rx_byte[7 - 2 * k];
                            if (n_group_count < 3'd4) begin
                                n_group_bits[n_group_count[1:0]] = w_bit;
                                n_group_count = n_group_count + 3'd1;
                            end else begin
                                if (!n_held) begin
                                    n_high = n_group_bits;
                                    n_held = 1'b1;
                                end else begin
                                    n_held = 1'b0;
                                    w_byte = {n_high, n_group_bits};
                                    w_got  = 1'b1;
                                end
                                n_group_bits  = '0;
                                n_group_count = '0;
                            end
                        end
                        if (w_got) begin
                            n_sum = r_sum + w_byte;
                            w_item0.data_byte = w_byte;
                            w_push = 2'd1;
                        end
                    end
                end
                default: ;
            endcase
            if (i_rx.end_of_buffer) begin
                if (n_phase != rfld_pkg::PHASE_CLOSED) begin
                    if (w_push == 2'd0) begin
                        w_item0.is_status   = 1'b1;
                        w_item0.header_seen = (n_phase != rfld_pkg::PHASE_SEARCH);
                        w_item0.sum_ok      = (n_sum == '0);
                    end else begin
                        w_item1.is_status   = 1'b1;
                        w_item1.header_seen = (n_phase != rfld_pkg::PHASE_SEARCH);
                        w_item1.sum_ok      = (n_sum == '0);
                    end
                    w_push = w_push + 2'd1;
                end
                n_window      = '0;
                n_fill        = '0;
                n_phase       = rfld_pkg::PHASE_SEARCH;
                n_group_bits  = '0;
                n_group_count = '0;
                n_high        = '0;
                n_held        = 1'b0;
                n_sum         = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window      <= '0;
            r_fill        <= '0;
            r_phase       <= rfld_pkg::PHASE_SEARCH;
            r_group_bits  <= '0;
            r_group_count <= '0;
            r_high        <= '0;
            r_held        <= 1'b0;
            r_sum         <= '0;
        end else begin
            r_window      <= n_window;
            r_fill        <= n_fill;
            r_phase       <= n_phase;
            r_group_bits  <= n_group_bits;
            r_group_count <= n_group_count;
            r_high        <= n_high;
            r_held        <= n_held;
            r_sum         <= n_sum;
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (w_push != 2'd0) begin
            r_mem[r_tail] <= w_item0;
        end
        if (w_push == 2'd2) begin
            r_mem[w_tail1] <= w_item1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= r_tail + rfld_pkg::Q_AW'(w_push);
            r_head  <= r_head + rfld_pkg::Q_AW'(w_out_acc);
            r_count <= r_count + rfld_pkg::Q_CW'(w_push) - rfld_pkg::Q_CW'(w_out_acc);
        end
    end

    assign o_res.valid       = (r_count != '0);
    assign o_res.data_byte   = r_mem[r_head].data_byte;
    assign o_res.is_status   = r_mem[r_head].is_status;
    assign o_res.header_seen = r_mem[r_head].header_seen;
    assign o_res.footer_seen = r_mem[r_head].footer_seen;
    assign o_res.sum_ok      = r_mem[r_head].sum_ok;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rfld_pkg::Q_CW'(rfld_pkg::Q_DEPTH))
        else $error("result queue overflow");

    a_eob_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_rx.end_of_buffer) |=>
            (r_phase == rfld_pkg::PHASE_SEARCH && r_fill == '0 && r_sum == '0))
        else $error("frame state not cleared after end of buffer");

    a_phase_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != rfld_pkg::PHASE_SEARCH) |-> (r_fill == 3'(rfld_pkg::HDR_LEN)))
        else $error("decode phase without a full header window");

    a_group_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_group_count <= 3'd4)
        else $error("line bit group count out of range");

endmodule
